### rtl/core/ir_pulse_width_decoder_macros.svh
// ----------------------------------------------------------------------------
// IR pulse width decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_DECODER_MACROS_SVH
`define IR_PULSE_WIDTH_DECODER_MACROS_SVH

// Same-cycle implication.
`define IRPWD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IRPWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/irpwd_pkg.sv
// ----------------------------------------------------------------------------
// irpwd_pkg
// Types, constants and helpers shared by the IR pulse width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpwd_pkg;

  localparam int unsigned CODE_BITS_DEF = 32;
  localparam int unsigned DUR_W         = 14;
  localparam int unsigned TOL_W         = 10;
  localparam int unsigned CODE_W        = 32;
  localparam int unsigned COUNT_W       = 6;
  localparam int unsigned APB_ADDR_W    = 5;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [TOL_W-1:0] TOLERANCE_RST    = TOL_W'(200);
  localparam logic [DUR_W-1:0] HEADER_MARK_RST  = DUR_W'(9000);
  localparam logic [DUR_W-1:0] HEADER_SPACE_RST = DUR_W'(4500);
  localparam logic [DUR_W-1:0] GAP_RST          = DUR_W'(550);
  localparam logic [DUR_W-1:0] ZERO_TIME_RST    = DUR_W'(600);
  localparam logic [DUR_W-1:0] ONE_TIME_RST     = DUR_W'(1600);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOISE     = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TIMING    = 2'd3
  } irpwd_status_e;

  typedef enum logic [2:0] {
    REG_TOLERANCE    = 3'd0,
    REG_HEADER_MARK  = 3'd1,
    REG_HEADER_SPACE = 3'd2,
    REG_GAP          = 3'd3,
    REG_ZERO_TIME    = 3'd4,
    REG_ONE_TIME     = 3'd5
  } irpwd_reg_e;

  typedef struct packed {
    logic [TOL_W-1:0] tolerance_us;
    logic [DUR_W-1:0] header_mark_us;
    logic [DUR_W-1:0] header_space_us;
    logic [DUR_W-1:0] gap_us;
    logic [DUR_W-1:0] zero_time_us;
    logic [DUR_W-1:0] one_time_us;
  } irpwd_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    irpwd_status_e      status;
    logic [COUNT_W-1:0] bit_count;
  } irpwd_result_t;

  // Strict absolute-difference window check.
  function automatic logic near_time(logic [DUR_W-1:0] meas, logic [DUR_W-1:0] nom,
                                     logic [TOL_W-1:0] tol);
    logic [DUR_W-1:0] diff;
    diff = (meas >= nom) ? (meas - nom) : (nom - meas);
    return diff < DUR_W'(tol);
  endfunction

endpackage

`default_nettype wire

### rtl/core/irpwd_cfg.sv
// ----------------------------------------------------------------------------
// irpwd_cfg
// APB register file holding the timing windows of the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module irpwd_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [irpwd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [irpwd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [irpwd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                  pready,
  output irpwd_pkg::irpwd_cfg_t                 cfg_o
);
  import irpwd_pkg::*;

  irpwd_cfg_t cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  // Byte offset bits are ignored; the word index selects the register.
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tolerance_us    <= TOLERANCE_RST;
      cfg_q.header_mark_us  <= HEADER_MARK_RST;
      cfg_q.header_space_us <= HEADER_SPACE_RST;
      cfg_q.gap_us          <= GAP_RST;
      cfg_q.zero_time_us    <= ZERO_TIME_RST;
      cfg_q.one_time_us     <= ONE_TIME_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_TOLERANCE:    cfg_q.tolerance_us    <= pwdata[TOL_W-1:0];
        REG_HEADER_MARK:  cfg_q.header_mark_us  <= pwdata[DUR_W-1:0];
        REG_HEADER_SPACE: cfg_q.header_space_us <= pwdata[DUR_W-1:0];
        REG_GAP:          cfg_q.gap_us          <= pwdata[DUR_W-1:0];
        REG_ZERO_TIME:    cfg_q.zero_time_us    <= pwdata[DUR_W-1:0];
        REG_ONE_TIME:     cfg_q.one_time_us     <= pwdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TOLERANCE:    prdata = APB_DATA_W'(cfg_q.tolerance_us);
      REG_HEADER_MARK:  prdata = APB_DATA_W'(cfg_q.header_mark_us);
      REG_HEADER_SPACE: prdata = APB_DATA_W'(cfg_q.header_space_us);
      REG_GAP:          prdata = APB_DATA_W'(cfg_q.gap_us);
      REG_ZERO_TIME:    prdata = APB_DATA_W'(cfg_q.zero_time_us);
      REG_ONE_TIME:     prdata = APB_DATA_W'(cfg_q.one_time_us);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/irpwd_frame.sv
// ----------------------------------------------------------------------------
// irpwd_frame
// Held reading register and per-frame state: header check, gap check and
// LSB-first bit accumulation. Presents the frame verdict combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module irpwd_frame #(
  parameter int unsigned CODE_BITS = irpwd_pkg::CODE_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        take_i,
  input  wire logic                        close_i,
  input  wire logic                        level_i,
  input  wire logic [irpwd_pkg::DUR_W-1:0] duration_us_i,
  input  wire irpwd_pkg::irpwd_cfg_t       cfg_i,
  output irpwd_pkg::irpwd_result_t         result_o
);
  import irpwd_pkg::*;

  localparam int unsigned BT_W  = $clog2(CODE_BITS + 1);
  localparam int unsigned IDX_W = $clog2(CODE_BITS);
  localparam logic [2:0]  IDX_MARK  = 3'd0;
  localparam logic [2:0]  IDX_SPACE = 3'd1;
  localparam logic [2:0]  IDX_GAP   = 3'd2;
  localparam logic [2:0]  IDX_FULL  = 3'd5;

  logic                 held_valid_q, held_valid_d;
  logic                 held_level_q, held_level_d;
  logic [DUR_W-1:0]     held_dur_q, held_dur_d;
  logic [2:0]           rd_idx_q, rd_idx_d;
  logic                 hdr_good_q, hdr_good_d;
  irpwd_status_e        fault_q, fault_d;
  logic [CODE_BITS-1:0] acc_q, acc_d;
  logic [BT_W-1:0]      bits_q, bits_d;

  logic near_mark, near_space, near_zero, near_one, is_gap;
  logic process;

  assign near_mark  = near_time(held_dur_q, cfg_i.header_mark_us, cfg_i.tolerance_us);
  assign near_space = near_time(held_dur_q, cfg_i.header_space_us, cfg_i.tolerance_us);
  assign near_zero  = near_time(held_dur_q, cfg_i.zero_time_us, cfg_i.tolerance_us);
  assign near_one   = near_time(held_dur_q, cfg_i.one_time_us, cfg_i.tolerance_us);
  assign is_gap     = !held_level_q &&
                      near_time(held_dur_q, cfg_i.gap_us, cfg_i.tolerance_us);
  assign process    = take_i && held_valid_q;

  always_comb begin
    held_valid_d = held_valid_q;
    held_level_d = held_level_q;
    held_dur_d   = held_dur_q;
    rd_idx_d     = rd_idx_q;
    hdr_good_d   = hdr_good_q;
    fault_d      = fault_q;
    acc_d        = acc_q;
    bits_d       = bits_q;

    if (close_i) begin
      // Drop the held reading and start a fresh frame.
      held_valid_d = 1'b0;
      held_level_d = 1'b0;
      held_dur_d   = '0;
      rd_idx_d     = IDX_MARK;
      hdr_good_d   = 1'b1;
      fault_d      = ST_OK;
      acc_d        = '0;
      bits_d       = '0;
    end else if (take_i) begin
      held_valid_d = 1'b1;
      held_level_d = level_i;
      held_dur_d   = duration_us_i;
      if (process) begin
        priority if (rd_idx_q == IDX_MARK) begin
          if (!near_mark) hdr_good_d = 1'b0;
        end else if (rd_idx_q == IDX_SPACE) begin
          if (!near_space) hdr_good_d = 1'b0;
        end else if (rd_idx_q == IDX_GAP) begin
          if (!is_gap && fault_q == ST_OK) fault_d = ST_MALFORMED;
        end else if (!is_gap) begin
          if (!near_zero && !near_one && fault_q == ST_OK) fault_d = ST_TIMING;
          if (bits_q < BT_W'(CODE_BITS)) begin
            // A reading near both times decodes as zero.
            acc_d[bits_q[IDX_W-1:0]] = !near_zero && near_one;
            bits_d = bits_q + BT_W'(1);
          end
        end
        if (rd_idx_q < IDX_FULL) rd_idx_d = rd_idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_level_q <= 1'b0;
      held_dur_q   <= '0;
      rd_idx_q     <= IDX_MARK;
      hdr_good_q   <= 1'b1;
      fault_q      <= ST_OK;
      acc_q        <= '0;
      bits_q       <= '0;
    end else begin
      held_valid_q <= held_valid_d;
      held_level_q <= held_level_d;
      held_dur_q   <= held_dur_d;
      rd_idx_q     <= rd_idx_d;
      hdr_good_q   <= hdr_good_d;
      fault_q      <= fault_d;
      acc_q        <= acc_d;
      bits_q       <= bits_d;
    end
  end

  always_comb begin
    priority if (rd_idx_q < IDX_GAP || !hdr_good_q) begin
      result_o.status = ST_NOISE;
    end else if (rd_idx_q < IDX_FULL) begin
      result_o.status = ST_MALFORMED;
    end else begin
      result_o.status = fault_q;
    end
    if (result_o.status == ST_OK) begin
      result_o.code      = CODE_W'(acc_q);
      result_o.bit_count = COUNT_W'(bits_q);
    end else begin
      result_o.code      = '0;
      result_o.bit_count = '0;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ir_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder
// Latency: one result per end-of-frame transaction, valid the cycle after it.
// Throughput: one input transaction per cycle; readings never produce output.
// An end-of-frame transaction stalls only while the result register is full
// and not being drained. Reset clears frame state and result, presets config.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_decoder #(
  parameter int unsigned CODE_BITS = irpwd_pkg::CODE_BITS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               level_i,
  input  wire logic [irpwd_pkg::DUR_W-1:0]        duration_us_i,
  input  wire logic                               end_of_frame_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [irpwd_pkg::CODE_W-1:0]       code_o,
  output logic      [1:0]                         status_o,
  output logic      [irpwd_pkg::COUNT_W-1:0]      bit_count_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [irpwd_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [irpwd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [irpwd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                    pready
);
  import irpwd_pkg::*;

  irpwd_cfg_t    cfg;
  irpwd_result_t frame_res;
  irpwd_result_t res_q;
  logic          out_valid_q;
  logic          in_fire, take, close;

  // Readings never need the result register, so only a frame close can stall.
  assign in_ready_o = !end_of_frame_i || !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign take       = in_fire && !end_of_frame_i;
  assign close      = in_fire && end_of_frame_i;

  irpwd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  irpwd_frame #(
    .CODE_BITS (CODE_BITS)
  ) u_frame (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (take),
    .close_i       (close),
    .level_i       (level_i),
    .duration_us_i (duration_us_i),
    .cfg_i         (cfg),
    .result_o      (frame_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (close) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on frame close, hold otherwise.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (close) begin
      res_q <= frame_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign code_o      = res_q.code;
  assign status_o    = res_q.status;
  assign bit_count_o = res_q.bit_count;

endmodule

`default_nettype wire

### rtl/core/irpwd_checker.sv
// ----------------------------------------------------------------------------
// irpwd_checker
// Port-level checks of the IR pulse width decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_decoder_macros.svh"

module irpwd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        end_of_frame_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] code_o,
  input wire logic [1:0]  status_o,
  input wire logic [5:0]  bit_count_o
);
  import irpwd_pkg::*;

  `IRPWD_ASSERT_NEXT(a_close_gives_result, in_valid_i && in_ready_o && end_of_frame_i, out_valid_o, "frame close produced no result")
  `IRPWD_ASSERT_SAME(a_stall_only_on_full, !in_ready_o, end_of_frame_i && out_valid_o && !out_ready_i, "input stalled without a pending result")
  `IRPWD_ASSERT_SAME(a_fault_clears_fields, out_valid_o && status_o != ST_OK, code_o == '0 && bit_count_o == '0, "faulted result carries code or bit count")
  `IRPWD_ASSERT_NEXT(a_result_holds, out_valid_o && !out_ready_i, out_valid_o && $stable(code_o) && $stable(status_o) && $stable(bit_count_o), "stalled result changed")

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (.*);

`default_nettype wire
